// File: src/rass_pkg.sv
`default_nettype none

package rass_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [31:0] FILL_WORD    = 32'hA5A5A5A5;
    localparam logic [15:0] BLX_MASK     = 16'hFF87;
    localparam logic [15:0] BLX_MATCH    = 16'h4780;
    localparam logic [15:0] BL_HI_MASK   = 16'hF800;
    localparam logic [15:0] BL_HI_MATCH  = 16'hF000;
    localparam logic [15:0] BL_LO_MASK   = 16'hD000;
    localparam logic [15:0] BL_LO_MATCH  = 16'hD000;
    localparam logic [31:0] REGION_MASK  = 32'hF0000000;
    localparam logic [31:0] PAIR_SPAN    = 32'd7;
    localparam logic [31:0] MIN_CODE_GAP = 32'd4;

    localparam logic [31:0] CODE_BASE_RST  = 32'h08000000;
    localparam logic [31:0] CODE_END_RST   = 32'h08010000;
    localparam logic [31:0] SRAM_BASE_RST  = 32'h20000000;
    localparam logic [31:0] SRAM_END_RST   = 32'h20030000;
    localparam logic [31:0] CCM_BASE_RST   = 32'h10000000;
    localparam logic [31:0] CCM_LAST_RST   = 32'h1000FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODE_BASE  = 3'd0,
        REG_CODE_END   = 3'd1,
        REG_SRAM_BASE  = 3'd2,
        REG_SRAM_END   = 3'd3,
        REG_CCM_BASE   = 3'd4,
        REG_CCM_LAST   = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_PC    = 2'd1,
        OP_LR    = 2'd2,
        OP_WORD  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STOP_RUN   = 3'd0,
        STOP_FULL  = 3'd1,
        STOP_RAM   = 3'd2,
        STOP_FILL  = 3'd3,
        STOP_LIMIT = 3'd4
    } stop_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] cand_value;
        logic [31:0] word_addr;
        logic [31:0] next_word;
        logic [15:0] half_minus_two;
        logic [15:0] half_minus_four;
    } cmd_t;

    typedef struct packed {
        logic        added;
        logic [3:0]  entry_index;
        logic [31:0] entry_value;
        logic [4:0]  entry_count;
        stop_t       stop_cause;
    } res_t;

    typedef struct packed {
        logic [31:0] code_base;
        logic [31:0] code_end;
        logic [31:0] sram_base;
        logic [31:0] sram_end;
        logic [31:0] ccm_base;
        logic [31:0] ccm_last;
    } cfg_t;

    typedef struct packed {
        logic pc_code;
        logic ret_ok;
        logic pair_ram;
        logic fill_pair;
    } chk_t;

endpackage

`default_nettype wire

// File: src/return_address_stack_scanner.sv
// Return-address stack scanner.
// cmd channel (cmd_valid/cmd_stall/cmd) takes one item per cycle unless stalled:
// a start command, the fault PC, the fault LR or one stack word with its address,
// the next word and the two code halfwords below the address it holds. res channel
// (res_valid/res_stall/res) returns exactly one result per item, in order,
// telling whether an entry was appended, where, and the list and stop status.
// An item goes from the input register to the result register; throughput is
// one item per cycle while res_stall is low, set by the single pass through
// the address checks and the last-entry compare into the result register.
// Only the last appended entry is held; earlier entries leave on res.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the six address
// bounds; cfg_ready is always high and indexes beyond the list are ignored.
// Write configuration only while no item is in flight.
// Reset clears the list, the scan count and the stop status, and loads the
// default bounds. While res_stall is high the result holds; one further item
// is absorbed by the input register, then cmd_stall rises.
`default_nettype none

module return_address_stack_scanner
    import rass_pkg::*;
#(
    parameter int LIST_DEPTH = 16,
    parameter int SCAN_LIMIT = 1024
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire cmd_t                 cmd,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output res_t                      res,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int WS_W  = $clog2(SCAN_LIMIT + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
    localparam logic [WS_W-1:0]  LIMIT_C = WS_W'(SCAN_LIMIT);

    cfg_t cfg;
    chk_t chk;

    logic             s1_valid_reg;
    cmd_t             s1_reg;
    logic             res_valid_reg;
    res_t             res_reg;
    res_t             res_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [WS_W-1:0]  ws_reg, ws_next;
    stop_t            stop_reg, stop_next;
    logic [31:0]      last_reg, last_next;

    logic             advance;
    logic             accept;
    logic             want_app;
    logic [31:0]      app_val;

    assign cfg_ready = 1'b1;

    rass_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rass_check u_check (
        .cfg  (cfg),
        .item (s1_reg),
        .chk  (chk)
    );

    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = s1_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        count_next = count_reg;
        ws_next    = ws_reg;
        stop_next  = stop_reg;
        last_next  = last_reg;
        want_app   = 1'b0;
        app_val    = s1_reg.cand_value;
        res_next   = '0;

        case (s1_reg.op)
            OP_START:
            begin
                count_next = '0;
                ws_next    = '0;
                stop_next  = STOP_RUN;
            end
            OP_PC:
            begin
                if (stop_reg == STOP_RUN && chk.pc_code)
                begin
                    want_app = 1'b1;
                    app_val  = {s1_reg.cand_value[31:1], 1'b1};
                end
            end
            OP_LR:
            begin
                if (stop_reg == STOP_RUN && chk.ret_ok)
                    want_app = 1'b1;
            end
            OP_WORD:
            begin
                if (stop_reg == STOP_RUN)
                begin
                    if (ws_reg >= LIMIT_C)
                        stop_next = STOP_LIMIT;
                    else if (count_reg >= DEPTH_C)
                        stop_next = STOP_FULL;
                    else if (!chk.pair_ram)
                        stop_next = STOP_RAM;
                    else if (chk.fill_pair)
                        stop_next = STOP_FILL;
                    else
                    begin
                        ws_next  = ws_reg + 1'b1;
                        want_app = chk.ret_ok;
                    end
                end
            end
            default: ;
        endcase

        if (want_app && count_reg < DEPTH_C &&
            !(count_reg != '0 && last_reg == app_val))
        begin
            res_next.added       = 1'b1;
            res_next.entry_index = 4'(count_reg);
            res_next.entry_value = app_val;
            last_next            = app_val;
            count_next           = count_reg + 1'b1;
        end

        res_next.entry_count = 5'(count_next);
        res_next.stop_cause  = stop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            count_reg     <= '0;
            ws_reg        <= '0;
            stop_reg      <= STOP_RUN;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;

            if (advance)
            begin
                count_reg <= count_next;
                ws_reg    <= ws_next;
                stop_reg  <= stop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= cmd;
        if (advance)
        begin
            res_reg  <= res_next;
            last_reg <= last_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// File: src/rass_cfg.sv
`default_nettype none

module rass_cfg
    import rass_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [31:0]          wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_base  <= CODE_BASE_RST;
            cfg_reg.code_end   <= CODE_END_RST;
            cfg_reg.sram_base  <= SRAM_BASE_RST;
            cfg_reg.sram_end   <= SRAM_END_RST;
            cfg_reg.ccm_base   <= CCM_BASE_RST;
            cfg_reg.ccm_last   <= CCM_LAST_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_CODE_BASE:  cfg_reg.code_base  <= wr_data;
                REG_CODE_END:   cfg_reg.code_end   <= wr_data;
                REG_SRAM_BASE:  cfg_reg.sram_base  <= wr_data;
                REG_SRAM_END:   cfg_reg.sram_end   <= wr_data;
                REG_CCM_BASE:   cfg_reg.ccm_base   <= wr_data;
                REG_CCM_LAST:   cfg_reg.ccm_last   <= wr_data;
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: src/rass_check.sv
`default_nettype none

module rass_check
    import rass_pkg::*;
(
    input  wire cfg_t cfg,
    input  wire cmd_t item,
    output chk_t      chk
);

    logic [31:0] cand_even;
    logic [31:0] pair_last;
    logic        in_code;
    logic        blx_hit;
    logic        bl_hit;

    function automatic logic in_ram(input logic [31:0] a, input cfg_t c);
        in_ram = (a >= c.sram_base && a < c.sram_end) ||
                 (a >= c.ccm_base && a <= c.ccm_last);
    endfunction

    assign cand_even = {item.cand_value[31:1], 1'b0};
    assign pair_last = item.word_addr + PAIR_SPAN;

    assign in_code = (cand_even >= cfg.code_base) && (cand_even < cfg.code_end);
    assign blx_hit = (item.half_minus_two & BLX_MASK) == BLX_MATCH;
    assign bl_hit  = ((item.half_minus_four & BL_HI_MASK) == BL_HI_MATCH) &&
                     ((item.half_minus_two & BL_LO_MASK) == BL_LO_MATCH);

    assign chk.pc_code   = in_code;
    assign chk.ret_ok    = item.cand_value[0] && in_code &&
                           ((cand_even - cfg.code_base) >= MIN_CODE_GAP) &&
                           (blx_hit || bl_hit);
    assign chk.pair_ram  = (item.word_addr[1:0] == 2'b00) &&
                           in_ram(item.word_addr, cfg) && in_ram(pair_last, cfg) &&
                           (((item.word_addr ^ pair_last) & REGION_MASK) == 32'd0);
    assign chk.fill_pair = (item.cand_value == FILL_WORD) && (item.next_word == FILL_WORD);

endmodule

`default_nettype wire
